[rtl/clfr_pkg.sv]
// Shared constants and types for the CR LF line frame receiver.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none
package clfr_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Default store depth.
  localparam int unsigned STORE_DEPTH_DEF = 128;

  // Line framing characters.
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  // Register reset values.
  localparam logic [CNT_W-1:0]  MAX_LENGTH_RST      = 7'd100;
  localparam logic [CNT_W-1:0]  REJECT_POSITION_RST = 7'd5;
  localparam logic [BYTE_W-1:0] REJECT_VALUE_RST    = 8'hA4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_POSITION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_VALUE    = 2'd2;

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_RX_BYTE = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } opcode_t;

endpackage
`default_nettype wire

[rtl/clfr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none
module clfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Read data holds when no read is issued.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/crlf_line_frame_receiver_unit.sv]
// Top level of the CR LF line frame receiver: framing control, line store and
// result buffering. Depends on clfr_pkg and clfr_ram.
`default_nettype none
// How to use this block:
// Requests enter on the in_ channel (in_valid / in_stall). Each request is one
// of three opcodes: a received serial byte, a read of a stored byte by index,
// or a release of the held frame. Every request yields exactly one result on
// the out_ channel (out_valid / out_stall) carrying the frame flags, the line
// length after the request and, for reads, the stored byte.
// The framing state is updated in the cycle a request is accepted, and the
// line store RAM is written or read in that same cycle. The RAM read data is
// registered, so the result waits in a pipeline register and then moves into
// the output register, which drives out_valid; while the output register is
// stalled it stays in the pipeline register. Throughput is one request per
// cycle while in_stall is low; the framing update loop is combinational.
// The output register and the pipeline register together act as a skid:
// while a finished result waits on out_stall, one more request is still
// accepted. in_stall rises only when both registers hold results.
// Reset (rst_n low, synchronous) clears the count, flags, pipeline valids and
// restores the register defaults; the line store is not cleared, and reading
// an entry that was never written returns an undefined byte.
// Configuration writes (cfg_valid / cfg_ready) are always accepted and should
// only be made while no request is in flight.
module crlf_line_frame_receiver_unit #(
  parameter int unsigned STORE_DEPTH = clfr_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Request channel.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [clfr_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [clfr_pkg::BYTE_W-1:0]     in_rx_byte,
  input  wire logic [clfr_pkg::CNT_W-1:0]      in_read_index,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_frame_ready,
  output logic                                 out_frame_done,
  output logic                                 out_cr_pending,
  output logic      [clfr_pkg::CNT_W-1:0]      out_length,
  output logic      [clfr_pkg::BYTE_W-1:0]     out_read_data,
  // Configuration write channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [clfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [clfr_pkg::BYTE_W-1:0]     cfg_data
);

  localparam int unsigned CNT_W  = clfr_pkg::CNT_W;
  localparam int unsigned BYTE_W = clfr_pkg::BYTE_W;
  localparam int unsigned AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  // Compare width that holds both a count or index and the depth itself.
  localparam int unsigned CMP_W  = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  // Configuration registers.
  logic [CNT_W-1:0]  max_length_r;
  logic [CNT_W-1:0]  reject_pos_r;
  logic [BYTE_W-1:0] reject_val_r;

  // Framing state.
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             cr_seen_r, cr_seen_nxt;
  logic             done_r, done_nxt;
  logic             ready_nxt;

  // Pipeline register (waits for RAM read data) and output register.
  logic             p_valid_r;
  logic             p_ready_r, p_done_r, p_cr_r, p_rd_hit_r;
  logic [CNT_W-1:0] p_len_r;

  logic              o_valid_r;
  logic              o_ready_r, o_done_r, o_cr_r;
  logic [CNT_W-1:0]  o_len_r;
  logic [BYTE_W-1:0] o_data_r;

  logic              accept;
  logic              o_free;
  logic              p_move;
  logic              is_rx, is_read, is_release;
  logic              wr_en, rd_en;
  logic [CNT_W:0]    count_inc;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] ram_q;

  // ---------------------------------------------------------------------------
  // Handshakes. The output register frees up when empty or taken this cycle;
  // the pipeline register moves forward whenever the output register is free.
  // ---------------------------------------------------------------------------
  assign o_free   = !o_valid_r || !out_stall;
  assign p_move   = p_valid_r && o_free;
  assign in_stall = p_valid_r && !o_free;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign is_rx      = (in_opcode == clfr_pkg::OP_RX_BYTE);
  assign is_read    = (in_opcode == clfr_pkg::OP_READ);
  assign is_release = (in_opcode == clfr_pkg::OP_RELEASE);

  // ---------------------------------------------------------------------------
  // Framing update for one request.
  // ---------------------------------------------------------------------------
  assign count_inc = {1'b0, byte_count_r} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    byte_count_nxt = byte_count_r;
    cr_seen_nxt    = cr_seen_r;
    done_nxt       = done_r;
    ready_nxt      = 1'b0;
    wr_en          = 1'b0;
    if (is_release) begin
      byte_count_nxt = '0;
      cr_seen_nxt    = 1'b0;
      done_nxt       = 1'b0;
    end else if (is_rx && !done_r) begin
      if (cr_seen_r) begin
        // Line feed completes the frame; anything else restarts the line.
        if (in_rx_byte == clfr_pkg::CHAR_LF) begin
          done_nxt  = 1'b1;
          ready_nxt = 1'b1;
        end else begin
          byte_count_nxt = '0;
          cr_seen_nxt    = 1'b0;
        end
      end else if (in_rx_byte == clfr_pkg::CHAR_CR) begin
        cr_seen_nxt = 1'b1;
      end else begin
        // The byte is stored even when the new count then restarts the line.
        wr_en = (CMP_W'(byte_count_r) < CMP_W'(STORE_DEPTH));
        if (count_inc > {1'b0, max_length_r}) begin
          byte_count_nxt = '0;
        end else if ((reject_pos_r != '0) && (count_inc[CNT_W-1:0] == reject_pos_r) &&
                     (in_rx_byte == reject_val_r)) begin
          byte_count_nxt = '0;
        end else begin
          byte_count_nxt = count_inc[CNT_W-1:0];
        end
      end
    end
  end

  assign wr_addr = AW'(byte_count_r);
  assign rd_addr = AW'(in_read_index);
  assign rd_en   = accept && is_read && (CMP_W'(in_read_index) < CMP_W'(STORE_DEPTH));

  clfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= clfr_pkg::MAX_LENGTH_RST;
      reject_pos_r <= clfr_pkg::REJECT_POSITION_RST;
      reject_val_r <= clfr_pkg::REJECT_VALUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        clfr_pkg::CFG_MAX_LENGTH:      max_length_r <= cfg_data[CNT_W-1:0];
        clfr_pkg::CFG_REJECT_POSITION: reject_pos_r <= cfg_data[CNT_W-1:0];
        clfr_pkg::CFG_REJECT_VALUE:    reject_val_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Framing state and pipeline control.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      cr_seen_r    <= 1'b0;
      done_r       <= 1'b0;
      p_valid_r    <= 1'b0;
      o_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        byte_count_r <= byte_count_nxt;
        cr_seen_r    <= cr_seen_nxt;
        done_r       <= done_nxt;
      end
      if (accept) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        o_valid_r <= 1'b1;
      end else if (!out_stall) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_ready_r  <= ready_nxt;
      p_done_r   <= done_nxt;
      p_cr_r     <= cr_seen_nxt;
      p_len_r    <= byte_count_nxt;
      p_rd_hit_r <= rd_en;
    end
    if (p_move) begin
      o_ready_r <= p_ready_r;
      o_done_r  <= p_done_r;
      o_cr_r    <= p_cr_r;
      o_len_r   <= p_len_r;
      o_data_r  <= p_rd_hit_r ? ram_q : '0;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_frame_ready = o_ready_r;
  assign out_frame_done  = o_done_r;
  assign out_cr_pending  = o_cr_r;
  assign out_length      = o_len_r;
  assign out_read_data   = o_data_r;

endmodule
`default_nettype wire

[test/tb_crlf_line_frame_receiver_unit.sv]
// Testbench for crlf_line_frame_receiver_unit: directed and random request
// streams, a line framing predictor and an in-order result scoreboard.
// Depends on clfr_pkg and the RTL of the receiver unit.
module tb_crlf_line_frame_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import clfr_pkg::*;

  // Opcode value that the block leaves without effect.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int LINE_DEPTH = STORE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;

  // One result as the block presents it on the out_ channel.
  typedef struct packed {
    logic              ready;
    logic              done;
    logic              cr;
    logic [CNT_W-1:0]  length;
    logic [BYTE_W-1:0] data;
  } frame_status_t;

  // Keeps a copy of the framing state and registers, predicts the result of
  // every accepted request and checks results in arrival order.
  class line_frame_scoreboard;
    logic [CNT_W-1:0]  max_length;
    logic [CNT_W-1:0]  reject_pos;
    logic [BYTE_W-1:0] reject_val;
    logic [CNT_W-1:0]  count;
    logic              cr_seen;
    logic              done;
    logic [BYTE_W-1:0] line_store [LINE_DEPTH];
    bit                stored [LINE_DEPTH];
    frame_status_t     expected_q [$];
    int                mismatches;

    function new();
      max_length = MAX_LENGTH_RST;
      reject_pos = REJECT_POSITION_RST;
      reject_val = REJECT_VALUE_RST;
      count      = '0;
      cr_seen    = 1'b0;
      done       = 1'b0;
      mismatches = 0;
      foreach (stored[i]) stored[i] = 1'b0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      case (idx)
        CFG_MAX_LENGTH:      max_length = data[CNT_W-1:0];
        CFG_REJECT_POSITION: reject_pos = data[CNT_W-1:0];
        CFG_REJECT_VALUE:    reject_val = data;
        default: ;
      endcase
    endfunction

    // Drops the partial line; bytes already in the store stay readable.
    function void restart_line();
      count   = '0;
      cr_seen = 1'b0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                               logic [CNT_W-1:0] idx);
      frame_status_t  r;
      logic [CNT_W:0] next_count;
      r = '0;
      case (op)
        OP_RX_BYTE: begin
          if (!done) begin
            if (cr_seen) begin
              if (b == CHAR_LF) begin
                done    = 1'b1;
                r.ready = 1'b1;
              end else begin
                restart_line();
              end
            end else if (b == CHAR_CR) begin
              cr_seen = 1'b1;
            end else begin
              line_store[count] = b;
              stored[count]     = 1'b1;
              // One bit wider so that a store at count 127 overflows the limit.
              next_count = {1'b0, count} + 1'b1;
              if (next_count > {1'b0, max_length}) begin
                restart_line();
              end else begin
                count = next_count[CNT_W-1:0];
                if (reject_pos != '0 && count == reject_pos && b == reject_val)
                  restart_line();
              end
            end
          end
        end
        OP_READ:    r.data = line_store[idx];
        OP_RELEASE: begin
          restart_line();
          done = 1'b0;
        end
        default: ;
      endcase
      r.done   = done;
      r.cr     = cr_seen;
      r.length = count;
      expected_q.push_back(r);
    endfunction

    function void check_result(frame_status_t got);
      frame_status_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request: ready=%0b done=%0b cr=%0b length=%0d data=%02h",
                   $time, got.ready, got.done, got.cr, got.length, got.data);
        return;
      end
      want = expected_q.pop_front();
      if (got.ready !== want.ready || got.done !== want.done || got.cr !== want.cr ||
          got.length !== want.length || got.data !== want.data) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected ready=%0b done=%0b cr=%0b length=%0d data=%02h, got ready=%0b done=%0b cr=%0b length=%0d data=%02h",
                   $time, want.ready, want.done, want.cr, want.length, want.data,
                   got.ready, got.done, got.cr, got.length, got.data);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // A random position that already holds a byte, or -1 when none does.
    function int pick_stored();
      int idx_q [$];
      foreach (stored[i]) if (stored[i]) idx_q.push_back(i);
      if (idx_q.size() == 0) return -1;
      return idx_q[$urandom_range(0, idx_q.size() - 1)];
    endfunction
  endclass

  // Every input of the block starts from a known value.
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode     = '0;
  logic [BYTE_W-1:0]    in_rx_byte    = '0;
  logic [CNT_W-1:0]     in_read_index = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 out_frame_ready;
  logic                 out_frame_done;
  logic                 out_cr_pending;
  logic [CNT_W-1:0]     out_length;
  logic [BYTE_W-1:0]    out_read_data;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [BYTE_W-1:0]    cfg_data      = '0;

  line_frame_scoreboard sb;
  int send_idle_pct = 0;  // chance in a hundred that the sender idles before a request
  int stall_pct     = 0;  // chance in a hundred that the receiver stalls on each clock
  int items_sent    = 0;  // requests accepted by the block
  int cycles        = 0;

  crlf_line_frame_receiver_unit u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Runaway guard: a hang anywhere in the block ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver stalls at random; with stall_pct at zero it never does.
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // All inputs change only at rising edges, so at the falling edge the handshake
  // signals show exactly what the next rising edge will see.
  always @(negedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result(frame_status_t'({out_frame_ready, out_frame_done, out_cr_pending,
                                        out_length, out_read_data}));

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CNT_W-1:0] rand_idx();
    return CNT_W'($urandom_range(0, 127));
  endfunction

  // Presents one request and returns at the edge that accepts it. in_valid is
  // left high so that back-to-back requests need no second assignment in the
  // same step; a random gap lowers it first.
  task automatic send_req(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                          logic [CNT_W-1:0] idx);
    logic taken;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_rx_byte    <= b;
    in_read_index <= idx;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    sb.note_request(op, b, idx);
  endtask

  // Reads only positions that were written at some point; before anything is
  // stored the slot goes to the unused opcode instead.
  task automatic send_read();
    int idx;
    idx = sb.pick_stored();
    if (idx < 0)
      send_req(OP_UNUSED, rand_byte(), rand_idx());
    else
      send_req(OP_READ, rand_byte(), idx[CNT_W-1:0]);
  endtask

  // Stops the sender and waits until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    sb.note_config(idx, data);
  endtask

  task automatic configure(logic [BYTE_W-1:0] max_len, logic [BYTE_W-1:0] rej_pos,
                           logic [BYTE_W-1:0] rej_val);
    cfg_write(CFG_MAX_LENGTH, max_len);
    cfg_write(CFG_REJECT_POSITION, rej_pos);
    cfg_write(CFG_REJECT_VALUE, rej_val);
    cfg_valid <= 1'b0;
  endtask

  // A line with random content: mostly short bodies, sometimes
  // longer than the limit, now and then the reject byte at the reject position.
  // Most lines end in CR LF, a few in CR and a wrong byte or in nothing. Then
  // some reads and, usually, the release.
  task automatic send_line();
    int                len;
    int                cap;
    logic [BYTE_W-1:0] b;
    cap = (sb.max_length < 10) ? sb.max_length : 10;
    if ($urandom_range(0, 4) == 0)
      len = $urandom_range(0, sb.max_length + 2);
    else
      len = $urandom_range(0, cap);
    for (int i = 0; i < len; i++) begin
      b = rand_byte();
      // A carriage return inside the body is kept rare so most lines survive.
      if (b == CHAR_CR && $urandom_range(0, 7) != 0) b = 8'h31;
      if (sb.reject_pos != '0 && i + 1 == sb.reject_pos && $urandom_range(0, 1) == 1)
        b = sb.reject_val;
      send_req(OP_RX_BYTE, b, rand_idx());
    end
    case ($urandom_range(0, 9))
      0: begin
        send_req(OP_RX_BYTE, CHAR_CR, rand_idx());
        b = rand_byte();
        if (b == CHAR_LF) b = 8'h00;
        send_req(OP_RX_BYTE, b, rand_idx());
      end
      1: ;
      default: begin
        send_req(OP_RX_BYTE, CHAR_CR, rand_idx());
        send_req(OP_RX_BYTE, CHAR_LF, rand_idx());
      end
    endcase
    repeat ($urandom_range(0, 3)) send_read();
    if ($urandom_range(0, 9) != 0) send_req(OP_RELEASE, rand_byte(), rand_idx());
  endtask

  // Loose requests outside any line structure.
  task automatic send_noise();
    case ($urandom_range(0, 5))
      0, 1:    send_req(OP_RX_BYTE, rand_byte(), rand_idx());
      2:       send_req(OP_RX_BYTE, CHAR_CR, rand_idx());
      3:       send_read();
      4:       send_req(OP_RELEASE, rand_byte(), rand_idx());
      default: send_req(OP_UNUSED, rand_byte(), rand_idx());
    endcase
  endtask

  task automatic run_random(int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) send_line();
      else send_noise();
    end
  endtask

  // Registers change only with nothing in flight, so each phase starts drained.
  task automatic run_phase(logic [BYTE_W-1:0] max_len, logic [BYTE_W-1:0] rej_pos,
                           logic [BYTE_W-1:0] rej_val, int idle, int stall, int n);
    drain();
    configure(max_len, rej_pos, rej_val);
    send_idle_pct = idle;
    stall_pct     = stall;
    run_random(n);
  endtask

  initial begin
    logic [BYTE_W-1:0] b;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values, no idling on either side.
    // A short frame with the byte extremes, then a byte that is ignored while
    // the frame is held, reads of what was stored, the unused opcode, release.
    send_req(OP_RX_BYTE, 8'h00, 7'h7F);
    send_req(OP_RX_BYTE, 8'hFF, 7'h00);
    send_req(OP_RX_BYTE, 8'h41, 7'h55);
    send_req(OP_RX_BYTE, CHAR_CR, 7'h00);
    send_req(OP_RX_BYTE, CHAR_LF, 7'h00);
    send_req(OP_RX_BYTE, 8'h55, 7'h2A);
    send_req(OP_READ, 8'hFF, 7'd0);
    send_req(OP_READ, 8'h00, 7'd1);
    send_req(OP_READ, 8'hAA, 7'd2);
    send_req(OP_UNUSED, 8'hFF, 7'h7F);
    send_req(OP_RELEASE, 8'h00, 7'h00);
    // A carriage return followed by anything but a line feed restarts the line,
    // a second carriage return included.
    send_req(OP_RX_BYTE, 8'h61, 7'h00);
    send_req(OP_RX_BYTE, CHAR_CR, 7'h00);
    send_req(OP_RX_BYTE, 8'h31, 7'h00);
    send_req(OP_RX_BYTE, CHAR_CR, 7'h00);
    send_req(OP_RX_BYTE, CHAR_CR, 7'h00);
    // The reject byte landing at the reject position discards the line.
    send_req(OP_RX_BYTE, 8'h01, 7'h00);
    send_req(OP_RX_BYTE, 8'h02, 7'h00);
    send_req(OP_RX_BYTE, 8'h03, 7'h00);
    send_req(OP_RX_BYTE, 8'h04, 7'h00);
    send_req(OP_RX_BYTE, REJECT_VALUE_RST, 7'h00);
    send_req(OP_READ, 8'h00, 7'd4);
    // Release with nothing held, then the unused opcode with all fields low.
    send_req(OP_RELEASE, 8'hFF, 7'h7F);
    send_req(OP_UNUSED, 8'h00, 7'h00);

    // Random phases, each with its own register setting and idling pattern.
    run_phase(8'd100, 8'd5, 8'hA4, 0, 0, 200);
    run_phase(8'd1, 8'd1, 8'h00, 65, 0, 200);

    // Largest limit, with bit 7 of the write data set to show it is dropped,
    // and the reject check off. A run of 128 body bytes stores at count 127 and
    // then overflows the limit, which also fills the whole line store.
    run_phase(8'hFF, 8'd0, 8'hFF, 0, 65, 100);
    send_req(OP_RELEASE, rand_byte(), rand_idx());
    for (int i = 0; i < 128; i++) begin
      b = rand_byte();
      if (b == CHAR_CR) b = 8'h20;
      send_req(OP_RX_BYTE, b, rand_idx());
    end
    repeat (8) send_read();
    run_random(100);

    run_phase(8'd8, 8'd127, 8'h31, 36, 36, 200);
    run_phase(8'd127, 8'd127, 8'h5A, 0, 0, 200);

    // Halfway through this phase the sender holds off until the block is empty.
    run_phase(8'd12, 8'd3, rand_byte(), 65, 0, 100);
    drain();
    run_random(100);

    run_phase(BYTE_W'($urandom_range(1, 127)), BYTE_W'($urandom_range(0, 127)),
              rand_byte(), 36, 36, 200);
    // Line feed as the reject byte at position two.
    run_phase(8'd20, 8'd2, CHAR_LF, 0, 65, 100);

    // Everything sent: let the last results come out, then watch for any stray
    // result before the verdict.
    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
